[hdl/rsdn_pkg.sv]
// Package: shared constants, types and state codes for the RootSIFT normalizer.
package rsdn_pkg;

  localparam int unsigned DescLenDefault     = 128;
  localparam int unsigned OutFracBitsDefault = 16;
  localparam int unsigned StoreDepth         = 64;
  localparam int unsigned SumW               = 23;
  localparam int unsigned ElemW              = 16;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EMIT,
    ST_WAIT
  } rsdn_state_t;

  // Control from the sequencer to each lane.
  typedef struct packed {
    logic start;
  } rsdn_lane_ctl_t;

endpackage

[hdl/rsdn_lane.sv]
// Lane: divides one element by the row sum and takes the square root, bit-serial.
module rsdn_lane #(
  parameter int unsigned OUT_FRAC_BITS = rsdn_pkg::OutFracBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rsdn_pkg::rsdn_lane_ctl_t          ctl,
  input  logic [rsdn_pkg::ElemW-1:0]        elem,
  input  logic [rsdn_pkg::SumW-1:0]         sum,
  output logic                              done,
  output logic [rsdn_pkg::ElemW-1:0]        result
);
  import rsdn_pkg::*;

  localparam int unsigned QW   = ElemW + 2 * OUT_FRAC_BITS;  // quotient width
  localparam int unsigned RW   = QW / 2 + 1;                 // root width
  localparam int unsigned DCNT = QW;
  localparam int unsigned SCNT = QW / 2 + (QW % 2);
  localparam int unsigned CW   = $clog2(DCNT + SCNT + 2);
  localparam logic [RW-1:0] SAT_OVER = RW'((OUT_FRAC_BITS >= ElemW) ?
                                       ((1 << ElemW) - 1) : ((1 << OUT_FRAC_BITS) - 1));

  logic [QW-1:0]   dividend_r, dividend_nxt;
  logic [SumW:0]   rem_r, rem_nxt;
  logic [QW+1:0]   sq_r, sq_nxt;          // radicand, shifted two bits a step
  logic [RW+1:0]   srem_r, srem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [SumW:0]   rem_sh;
  logic [RW+1:0]   s_try, s_sh;

  // Step one digit of the divide, then of the square root.
  always_comb begin
    dividend_nxt = dividend_r;
    rem_nxt      = rem_r;
    sq_nxt       = sq_r;
    srem_nxt     = srem_r;
    root_nxt     = root_r;
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    rem_sh       = {rem_r[SumW-1:0], dividend_r[QW-1]};
    s_sh         = {srem_r[RW-1:0], sq_r[QW+1:QW]};
    s_try        = {root_r, 2'b01};
    if (ctl.start) begin
      dividend_nxt = {elem, {(2*OUT_FRAC_BITS){1'b0}}};
      rem_nxt      = '0;
      srem_nxt     = '0;
      root_nxt     = '0;
      cnt_nxt      = '0;
      busy_nxt     = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r < CW'(DCNT)) begin
        dividend_nxt = {dividend_r[QW-2:0], 1'b0};
        if (rem_sh >= {1'b0, sum}) begin
          rem_nxt = rem_sh - {1'b0, sum};
          dividend_nxt[0] = 1'b1;
        end else begin
          rem_nxt = rem_sh;
        end
      end else if (cnt_r == CW'(DCNT)) begin
        // Load the quotient at the top of the radicand; its width is always even.
        sq_nxt = {dividend_r, 2'b00};
        if (sum == '0) sq_nxt = '0;
      end else begin
        sq_nxt = {sq_r[QW-1:0], 2'b00};
        if (s_sh >= s_try) begin
          srem_nxt = s_sh - s_try;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          srem_nxt = s_sh;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        if (cnt_r == CW'(DCNT + SCNT)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dividend_r <= dividend_nxt;
    rem_r      <= rem_nxt;
    sq_r       <= sq_nxt;
    srem_r     <= srem_nxt;
    root_r     <= root_nxt;
  end

  assign done   = done_r;
  assign result = (root_r > SAT_OVER) ? ElemW'(SAT_OVER) : ElemW'(root_r);

endmodule

[hdl/rootsift_descriptor_normalize.sv]
// Top level: row store, L1 sum, sequencer and two normalizing lanes.
// Pairs stream in at one per cycle while the row loads, each stored and added to a
// 23-bit L1 sum. On the pair marked tlast the block stops taking input and emits
// one transaction per stored pair. Each emitted pair runs through two bit-serial
// lanes (divide, then square root), one per element, after the store read, and the
// results go to one output register. The next pair is launched only after the
// previous result has been taken, so a stall on the result side holds the row.
// Pairs beyond DESC_LEN/2 (at most 64) are dropped but their tlast closes the row.
module rootsift_descriptor_normalize #(
  parameter int unsigned DESC_LEN      = rsdn_pkg::DescLenDefault,
  parameter int unsigned OUT_FRAC_BITS = rsdn_pkg::OutFracBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // elem_a [15:0], elem_b [31:16]
  input  logic        in_tlast,   // row_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // norm_a [15:0], norm_b [31:16]
  output logic        out_tlast   // last_pair
);
  import rsdn_pkg::*;

  localparam int unsigned CAP = (DESC_LEN / 2 > StoreDepth) ? StoreDepth : DESC_LEN / 2;
  localparam int unsigned AW  = $clog2(StoreDepth);

  logic [31:0]      store_mem [StoreDepth];
  logic [31:0]      rd_data_r;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic [AW:0]      idx_r, idx_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  rsdn_state_t      st_r, st_nxt;
  logic             rd_go_r, rd_go_nxt;
  logic             start_r;
  logic             ov_r, ov_nxt;
  logic             last_r, last_nxt;
  rsdn_lane_ctl_t   lane_ctl;
  logic             done_a, done_b;
  logic [ElemW-1:0] res_a, res_b;
  logic             in_acc, out_acc, store_wr;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign store_wr = in_acc && (cnt_r < (AW+1)'(CAP));

  // Write one pair per input transaction below capacity, read the pair at the emit index.
  always_ff @(posedge clk) begin
    if (store_wr) store_mem[cnt_r[AW-1:0]] <= in_tdata;
    rd_data_r <= store_mem[idx_r[AW-1:0]];
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD: if (in_acc && in_tlast) st_nxt = (cnt_nxt == '0) ? ST_LOAD : ST_EMIT;
      ST_EMIT: if (done_a) st_nxt = ST_WAIT;
      ST_WAIT: if (out_acc) st_nxt = (last_r) ? ST_LOAD : ST_EMIT;
      default: st_nxt = ST_LOAD;
    endcase
  end

  // Counters, sum and lane launch.
  always_comb begin
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    rd_go_nxt = 1'b0;
    ov_nxt    = ov_r;
    last_nxt  = last_r;
    if (store_wr) begin
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = sum_r + SumW'(in_tdata[15:0]) + SumW'(in_tdata[31:16]);
    end
    unique case (st_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) begin
          idx_nxt = '0;
          if (cnt_nxt != '0) rd_go_nxt = 1'b1;
          else sum_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (done_a) begin
          ov_nxt   = 1'b1;
          last_nxt = (idx_r + 1'b1 == cnt_r);
        end
      end
      ST_WAIT: begin
        if (out_acc) begin
          ov_nxt = 1'b0;
          if (last_r) begin
            cnt_nxt = '0;
            sum_nxt = '0;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            rd_go_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_LOAD;
      cnt_r   <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
      rd_go_r <= 1'b0;
      start_r <= 1'b0;
      ov_r    <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
      rd_go_r <= rd_go_nxt;
      start_r <= rd_go_r;
      ov_r    <= ov_nxt;
      last_r  <= last_nxt;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = (st_r == ST_LOAD);
  end

  // The read word is valid in the cycle after the address, when start is high.
  assign lane_ctl.start = start_r;

  rsdn_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane_a (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .elem(rd_data_r[15:0]),
    .sum(sum_r), .done(done_a), .result(res_a));

  rsdn_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane_b (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .elem(rd_data_r[31:16]),
    .sum(sum_r), .done(done_b), .result(res_b));

  // Merge the lane results into one output register.
  logic [31:0] out_data_r;
  always_ff @(posedge clk) begin
    if (done_a) out_data_r <= {res_b, res_a};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n) done_a == done_b)
    else $error("lanes out of step");
  a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken during emit");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(CAP))
    else $error("pair count beyond capacity");
`endif

endmodule
